FILE: src/accel_tilt_angles_top_defines.svh
// assertion macros for the tilt angle block
// used by accel_tilt_angles_top, expects clk and rst_n in scope
`ifndef ACCEL_TILT_ANGLES_TOP_DEFINES_SVH
`define ACCEL_TILT_ANGLES_TOP_DEFINES_SVH

// checked outside reset
`define ATA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define ATA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/atg_pkg.sv
// widths, constants and the atan table of the tilt angle block
// no dependencies
package atg_pkg;

  localparam int RAW_W     = 16;
  localparam int AXIS_W    = 20;
  localparam int GUARD     = 8;
  localparam int NUM_W     = AXIS_W + GUARD;
  localparam int SQ_W      = 37;
  localparam int SUM_W     = SQ_W + 1;
  localparam int RAD_W     = SUM_W + 2 * GUARD;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int CW        = NUM_W + 2;
  localparam int Z_W       = 32;
  localparam int TAB_FRAC  = 24;
  localparam int TAB_LEN   = 24;
  localparam int OUT_W     = 15;
  localparam int RC_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd3;

  localparam logic [RC_W-1:0]         RANGE_RST    = 2'd1;
  localparam logic signed [RAW_W-1:0] OFFSET_X_RST = 16'sd0;
  localparam logic signed [RAW_W-1:0] OFFSET_Y_RST = 16'sd328;
  localparam logic signed [RAW_W-1:0] OFFSET_Z_RST = 16'sd164;

  localparam logic signed [Z_W-1:0] ATAN_TAB [TAB_LEN] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
    32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
    32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
    32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
    32'sd917,       32'sd458,       32'sd229,       32'sd115
  };

  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctl_t;

endpackage

FILE: src/atg_if.sv
// channel interfaces of the tilt angle block: sample, angle and config write
// depends on atg_pkg
interface atg_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [atg_pkg::RAW_W-1:0]   accel_x;
  logic signed [atg_pkg::RAW_W-1:0]   accel_y;
  logic signed [atg_pkg::RAW_W-1:0]   accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atg_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [atg_pkg::OUT_W-1:0]   roll_angle;
  logic signed [atg_pkg::OUT_W-1:0]   pitch_angle;
  modport source (output valid, roll_angle, pitch_angle, input ready);
  modport sink (input valid, roll_angle, pitch_angle, output ready);
endinterface

interface atg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [atg_pkg::CFG_IDX_W-1:0]      index;
  logic [atg_pkg::CFG_DAT_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/atg_front.sv
// front end: axis scaling and offset, squares, radicands and numerators
// depends on atg_pkg
module atg_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  atg_pkg::pipe_ctl_t                  ctl,
  input  logic signed [atg_pkg::RAW_W-1:0]    raw_x,
  input  logic signed [atg_pkg::RAW_W-1:0]    raw_y,
  input  logic signed [atg_pkg::RAW_W-1:0]    raw_z,
  input  logic [atg_pkg::RC_W-1:0]            range_code,
  input  logic signed [atg_pkg::RAW_W-1:0]    offset_x,
  input  logic signed [atg_pkg::RAW_W-1:0]    offset_y,
  input  logic signed [atg_pkg::RAW_W-1:0]    offset_z,
  output logic                                vld_out,
  output logic [atg_pkg::RAD_W-1:0]           rad_roll,
  output logic [atg_pkg::RAD_W-1:0]           rad_pitch,
  output logic signed [atg_pkg::NUM_W-1:0]    num_roll,
  output logic signed [atg_pkg::NUM_W-1:0]    num_pitch
);

  logic signed [atg_pkg::AXIS_W-1:0] ax_r, ay_r, az_r;
  logic [atg_pkg::SQ_W-1:0]          sqx_r, sqy_r, sqz_r;
  logic signed [atg_pkg::NUM_W-1:0]  nr_r, np_r, nr2_r, np2_r;
  logic [atg_pkg::RAD_W-1:0]         radr_r, radp_r;
  logic                              v1_r, v2_r, v3_r;

  logic signed [2*atg_pkg::AXIS_W-1:0] px, py, pz;
  logic signed [atg_pkg::AXIS_W-1:0]   nax;
  logic [atg_pkg::SUM_W-1:0]           sum_r_nxt, sum_p_nxt;

  assign px  = ax_r * ax_r;
  assign py  = ay_r * ay_r;
  assign pz  = az_r * az_r;
  assign nax = -ax_r;
  assign sum_r_nxt = atg_pkg::SUM_W'(sqy_r) + atg_pkg::SUM_W'(sqz_r);
  assign sum_p_nxt = atg_pkg::SUM_W'(sqx_r) + atg_pkg::SUM_W'(sqz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ctl.adv) begin
      v1_r <= ctl.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      ax_r   <= (atg_pkg::AXIS_W'(raw_x) <<< range_code) + atg_pkg::AXIS_W'(offset_x);
      ay_r   <= (atg_pkg::AXIS_W'(raw_y) <<< range_code) + atg_pkg::AXIS_W'(offset_y);
      az_r   <= (atg_pkg::AXIS_W'(raw_z) <<< range_code) + atg_pkg::AXIS_W'(offset_z);
      sqx_r  <= px[atg_pkg::SQ_W-1:0];
      sqy_r  <= py[atg_pkg::SQ_W-1:0];
      sqz_r  <= pz[atg_pkg::SQ_W-1:0];
      nr_r   <= {nax, {atg_pkg::GUARD{1'b0}}};
      np_r   <= {ay_r, {atg_pkg::GUARD{1'b0}}};
      nr2_r  <= nr_r;
      np2_r  <= np_r;
      radr_r <= {sum_r_nxt, {(2*atg_pkg::GUARD){1'b0}}};
      radp_r <= {sum_p_nxt, {(2*atg_pkg::GUARD){1'b0}}};
    end
  end

  assign vld_out   = v3_r;
  assign rad_roll  = radr_r;
  assign rad_pitch = radp_r;
  assign num_roll  = nr2_r;
  assign num_pitch = np2_r;

endmodule

FILE: src/atg_isqrt.sv
// pipelined integer square root, one result bit per stage, numerator carried along
// depends on atg_pkg
module atg_isqrt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  atg_pkg::pipe_ctl_t                 ctl,
  input  logic [atg_pkg::RAD_W-1:0]          rad_in,
  input  logic signed [atg_pkg::NUM_W-1:0]   num_in,
  output logic                               vld_out,
  output logic [atg_pkg::ROOT_W-1:0]         root_out,
  output logic signed [atg_pkg::NUM_W-1:0]   num_out
);

  localparam int N = atg_pkg::ROOT_W;

  logic [atg_pkg::RAD_W-1:0]        rad_r  [N-1];
  logic [atg_pkg::REM_W-1:0]        rem_r  [N-1];
  logic [atg_pkg::ROOT_W-1:0]       root_r [N];
  logic signed [atg_pkg::NUM_W-1:0] num_r  [N];
  logic                             vld_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stg
    logic [atg_pkg::RAD_W-1:0]        rad_i;
    logic [atg_pkg::REM_W-1:0]        rem_i, rem_sh, trial;
    logic [atg_pkg::ROOT_W-1:0]       root_i;
    logic signed [atg_pkg::NUM_W-1:0] num_i;
    logic                             vld_i, ge;

    if (k == 0) begin : g_first
      assign rad_i  = rad_in;
      assign rem_i  = '0;
      assign root_i = '0;
      assign num_i  = num_in;
      assign vld_i  = ctl.vld;
    end else begin : g_next
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign num_i  = num_r[k-1];
      assign vld_i  = vld_r[k-1];
    end

    assign rem_sh = {rem_i[atg_pkg::REM_W-3:0], rad_i[atg_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_i, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl.adv) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        root_r[k] <= {root_i[atg_pkg::ROOT_W-2:0], ge};
        num_r[k]  <= num_i;
      end
    end

    if (k < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ctl.adv) begin
          rad_r[k] <= {rad_i[atg_pkg::RAD_W-3:0], 2'b00};
          rem_r[k] <= ge ? (rem_sh - trial) : rem_sh;
        end
      end
    end
  end

  assign vld_out  = vld_r[N-1];
  assign root_out = root_r[N-1];
  assign num_out  = num_r[N-1];

endmodule

FILE: src/atg_cordic.sv
// pipelined vectoring cordic, one rotation per stage, then rounding and saturation
// depends on atg_pkg
module atg_cordic #(
  parameter int STAGES          = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  atg_pkg::pipe_ctl_t                 ctl,
  input  logic [atg_pkg::ROOT_W-1:0]         den,
  input  logic signed [atg_pkg::NUM_W-1:0]   num,
  output logic                               vld_out,
  output logic signed [atg_pkg::OUT_W-1:0]   angle
);

  localparam int SH = atg_pkg::TAB_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [atg_pkg::Z_W-1:0] HALF  = atg_pkg::Z_W'(1) <<< (SH - 1);
  localparam logic signed [atg_pkg::Z_W-1:0] LIMIT = atg_pkg::Z_W'(90) <<< ANGLE_FRAC_BITS;

  logic signed [atg_pkg::CW-1:0]  x_r [STAGES-1];
  logic signed [atg_pkg::CW-1:0]  y_r [STAGES-1];
  logic signed [atg_pkg::Z_W-1:0] z_r [STAGES];
  logic                           dz_r  [STAGES];
  logic                           neg_r [STAGES];
  logic                           nz_r  [STAGES];
  logic                           vld_r [STAGES];

  logic signed [atg_pkg::OUT_W-1:0] ang_r;
  logic                             ovld_r;

  for (genvar k = 0; k < STAGES; k++) begin : g_stg
    logic signed [atg_pkg::CW-1:0]  x_i, y_i, xs, ys;
    logic signed [atg_pkg::Z_W-1:0] z_i;
    logic                           dz_i, neg_i, nz_i, vld_i;

    if (k == 0) begin : g_first
      assign x_i   = atg_pkg::CW'({1'b0, den});
      assign y_i   = atg_pkg::CW'(num);
      assign z_i   = '0;
      assign dz_i  = (den == '0);
      assign neg_i = num[atg_pkg::NUM_W-1];
      assign nz_i  = (num != '0);
      assign vld_i = ctl.vld;
    end else begin : g_next
      assign x_i   = x_r[k-1];
      assign y_i   = y_r[k-1];
      assign z_i   = z_r[k-1];
      assign dz_i  = dz_r[k-1];
      assign neg_i = neg_r[k-1];
      assign nz_i  = nz_r[k-1];
      assign vld_i = vld_r[k-1];
    end

    assign xs = x_i >>> k;
    assign ys = y_i >>> k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl.adv) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        z_r[k]   <= y_i[atg_pkg::CW-1] ? (z_i - atg_pkg::ATAN_TAB[k])
                                       : (z_i + atg_pkg::ATAN_TAB[k]);
        dz_r[k]  <= dz_i;
        neg_r[k] <= neg_i;
        nz_r[k]  <= nz_i;
      end
    end

    if (k < STAGES - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (ctl.adv) begin
          x_r[k] <= y_i[atg_pkg::CW-1] ? (x_i - ys) : (x_i + ys);
          y_r[k] <= y_i[atg_pkg::CW-1] ? (y_i + xs) : (y_i - xs);
        end
      end
    end
  end

  logic signed [atg_pkg::Z_W-1:0] zr, r, ang_nxt;

  always_comb begin
    zr = z_r[STAGES-1] + HALF;
    r  = zr >>> SH;
    if (dz_r[STAGES-1]) begin
      ang_nxt = !nz_r[STAGES-1] ? '0 : (neg_r[STAGES-1] ? -LIMIT : LIMIT);
    end else if (r > LIMIT) begin
      ang_nxt = LIMIT;
    end else if (r < -LIMIT) begin
      ang_nxt = -LIMIT;
    end else begin
      ang_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (ctl.adv) begin
      ovld_r <= vld_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      ang_r <= ang_nxt[atg_pkg::OUT_W-1:0];
    end
  end

  assign vld_out = ovld_r;
  assign angle   = ang_r;

endmodule

FILE: src/accel_tilt_angles_top.sv
// Accelerometer tilt angles, top level.
// Channels: in_ch takes one x/y/z raw sample per transaction, out_ch gives
// roll_angle and pitch_angle for it, cfg_ch writes range_code (index 0) and
// the x/y/z offsets (indexes 1 to 3); other indexes are ignored.
// cfg_ch is always ready; write it only while the pipeline is empty.
// Throughput: one sample per cycle while out_ch does not stall.
// Pipeline from input to output transaction: three front stages for
// scaling, squares and sums, one square root stage per result bit,
// one cordic stage per rotation, and one rounding stage that is also
// the output register.
// When out_ch stalls the whole pipeline holds and in_ch drops ready;
// nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// register defaults: range_code 1, offsets 0, 328, 164.
// Depends on atg_pkg, atg_if, atg_front, atg_isqrt, atg_cordic and the defines header.
`include "accel_tilt_angles_top_defines.svh"

module accel_tilt_angles_top #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  atg_in_if.sink    in_ch,
  atg_out_if.source out_ch,
  atg_cfg_if.sink   cfg_ch
);

  logic [atg_pkg::RC_W-1:0]         range_r;
  logic signed [atg_pkg::RAW_W-1:0] offx_r, offy_r, offz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= atg_pkg::RANGE_RST;
      offx_r  <= atg_pkg::OFFSET_X_RST;
      offy_r  <= atg_pkg::OFFSET_Y_RST;
      offz_r  <= atg_pkg::OFFSET_Z_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        atg_pkg::REG_RANGE:    range_r <= cfg_ch.data[atg_pkg::RC_W-1:0];
        atg_pkg::REG_OFFSET_X: offx_r  <= cfg_ch.data;
        atg_pkg::REG_OFFSET_Y: offy_r  <= cfg_ch.data;
        atg_pkg::REG_OFFSET_Z: offz_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  logic adv;
  logic roll_vld, pitch_vld;

  assign adv         = !roll_vld || out_ch.ready;
  assign in_ch.ready = adv;

  atg_pkg::pipe_ctl_t ctl_in;
  assign ctl_in.adv = adv;
  assign ctl_in.vld = in_ch.valid;

  logic                             f_vld;
  logic [atg_pkg::RAD_W-1:0]        rad_roll, rad_pitch;
  logic signed [atg_pkg::NUM_W-1:0] num_roll, num_pitch;

  atg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl_in),
    .raw_x      (in_ch.accel_x),
    .raw_y      (in_ch.accel_y),
    .raw_z      (in_ch.accel_z),
    .range_code (range_r),
    .offset_x   (offx_r),
    .offset_y   (offy_r),
    .offset_z   (offz_r),
    .vld_out    (f_vld),
    .rad_roll   (rad_roll),
    .rad_pitch  (rad_pitch),
    .num_roll   (num_roll),
    .num_pitch  (num_pitch)
  );

  atg_pkg::pipe_ctl_t ctl_sq;
  assign ctl_sq.adv = adv;
  assign ctl_sq.vld = f_vld;

  logic                             sr_vld, sp_vld;
  logic [atg_pkg::ROOT_W-1:0]       den_roll, den_pitch;
  logic signed [atg_pkg::NUM_W-1:0] nq_roll, nq_pitch;

  atg_isqrt u_sqrt_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_sq),
    .rad_in   (rad_roll),
    .num_in   (num_roll),
    .vld_out  (sr_vld),
    .root_out (den_roll),
    .num_out  (nq_roll)
  );

  atg_isqrt u_sqrt_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_sq),
    .rad_in   (rad_pitch),
    .num_in   (num_pitch),
    .vld_out  (sp_vld),
    .root_out (den_pitch),
    .num_out  (nq_pitch)
  );

  atg_pkg::pipe_ctl_t ctl_cr, ctl_cp;
  assign ctl_cr.adv = adv;
  assign ctl_cr.vld = sr_vld;
  assign ctl_cp.adv = adv;
  assign ctl_cp.vld = sp_vld;

  atg_cordic #(
    .STAGES          (CORDIC_STAGES),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_cr),
    .den     (den_roll),
    .num     (nq_roll),
    .vld_out (roll_vld),
    .angle   (out_ch.roll_angle)
  );

  atg_cordic #(
    .STAGES          (CORDIC_STAGES),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_cp),
    .den     (den_pitch),
    .num     (nq_pitch),
    .vld_out (pitch_vld),
    .angle   (out_ch.pitch_angle)
  );

  assign out_ch.valid = roll_vld;

  `ATA_ASSERT(a_lanes_aligned, roll_vld == pitch_vld, "roll and pitch lanes out of step")
  `ATA_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_ch.valid, "output valid after reset")
  `ATA_ASSERT(a_no_accept_on_stall, (in_ch.valid && in_ch.ready) |-> !(out_ch.valid && !out_ch.ready), "input taken while output stalled")
  `ATA_ASSERT(a_stall_holds_valid, (out_ch.valid && !out_ch.ready) |=> roll_vld && pitch_vld, "pending result dropped in stall")

endmodule
